>>> hw/rtl/hicolor_pixel_crossfade_macros.svh
// Assertion macros shared by the crossfade RTL.
`ifndef HICOLOR_PIXEL_CROSSFADE_MACROS_SVH
`define HICOLOR_PIXEL_CROSSFADE_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define HPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked implication check, masked while reset is asserted.
`define HPC_ASSERT_IMPL(lbl, ante, cons, msg) \
  `HPC_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

>>> hw/rtl/hpc_pkg.sv
// Types, constants and per-byte blend terms for the hicolor crossfade.
package hpc_pkg;

  localparam int unsigned PixW    = 16;
  localparam int unsigned LevelW  = 7;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 7;
  localparam int unsigned SumW    = 32;

  localparam logic [LevelW-1:0] LevelFull = 7'd64;

  localparam logic [SumW-1:0] Mask565 = 32'hFC1F03E0;
  localparam logic [SumW-1:0] Mask555 = 32'hF81F07C0;
  localparam int unsigned     Shift565 = 5;
  localparam int unsigned     Shift555 = 6;

  localparam logic [7:0] MaskLoBlue  = 8'h1F;
  localparam logic [7:0] MaskLoGreen = 8'hE0;
  localparam logic [7:0] MaskHiRed   = 8'hF8;
  localparam logic [7:0] MaskHiRed5  = 8'h7C;
  localparam logic [7:0] MaskHiGrn6  = 8'h07;
  localparam logic [7:0] MaskHiGrn5  = 8'h03;

  typedef enum logic {
    Rgb565 = 1'b0,
    Rgb555 = 1'b1
  } fmt_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPixelFormat = 2'd0,
    CfgFadeLevel   = 2'd1
  } cfg_idx_e;

  // Low byte: blue in lane 0, green in lane 21.
  function automatic logic [SumW-1:0] low_term(fmt_e fmt, logic [7:0] c,
                                               logic [LevelW-1:0] lvl);
    logic [14:0] pb;
    logic [14:0] pg;
    logic [14:0] b;
    logic [14:0] g;
    pb = 15'(c & MaskLoBlue) * 15'(lvl);
    pg = 15'(c & MaskLoGreen) * 15'(lvl);
    if (fmt == Rgb565) begin
      b = pb >> 1;
      g = pg >> 6;
    end else begin
      b = pb;
      g = pg >> 5;
    end
    return SumW'(b) | (SumW'(g) << 21);
  endfunction

  // High byte: red in lane 10/11, green bits in lane 21.
  function automatic logic [SumW-1:0] high_term(fmt_e fmt, logic [7:0] c,
                                                logic [LevelW-1:0] lvl);
    logic [14:0]     pr;
    logic [14:0]     pg;
    logic [SumW-1:0] g;
    logic [SumW-1:0] r;
    if (fmt == Rgb565) begin
      pg = 15'(c & MaskHiGrn6) * 15'(lvl);
      pr = 15'(c & MaskHiRed) * 15'(lvl);
      g  = SumW'(pg) << 2;
      r  = SumW'(pr >> 3) << 10;
    end else begin
      pg = 15'(c & MaskHiGrn5) * 15'(lvl);
      pr = 15'(c & MaskHiRed5) * 15'(lvl);
      g  = SumW'(pg) << 3;
      r  = SumW'(pr >> 3) << 11;
    end
    return r | (g << 21);
  endfunction

endpackage

>>> hw/rtl/hicolor_pixel_crossfade.sv
// Top level of the hicolor pixel crossfade: two-stage blend pipeline.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+----------------------------
//  in       | sink      | in_valid_i / in_stall_o | new_pixel_i, old_pixel_i
//  out      | source    | out_valid_o/out_stall_i | blended_pixel_o
//  cfg      | sink      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One item per clock while the output is not stalled; an item passes
// through the input register, then the result register, before its
// result is valid for the output handshake.
// The blend itself sits between those two registers: eight narrow products,
// a four-way 32-bit add, mask, fold and shift.
// in_stall_o follows a stalled output in the same cycle, but only while both
// registers hold an item; with the input stage empty an item is still taken
// while a finished result waits.
// rst_ni clears both valid flags and the config (RGB565, level 0).
`include "hicolor_pixel_crossfade_macros.svh"

module hicolor_pixel_crossfade (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // item input
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [hpc_pkg::PixW-1:0]     new_pixel_i,
  input  logic [hpc_pkg::PixW-1:0]     old_pixel_i,
  // item output
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [hpc_pkg::PixW-1:0]     blended_pixel_o,
  // config writes
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [hpc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [hpc_pkg::CfgDatW-1:0]  cfg_data_i
);

  // ---------------------------------------------------------------- config
  hpc_pkg::fmt_e                    fmt_q;
  logic [hpc_pkg::LevelW-1:0]       level_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q   <= hpc_pkg::Rgb565;
      level_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (hpc_pkg::cfg_idx_e'(cfg_index_i))
        hpc_pkg::CfgPixelFormat: fmt_q   <= hpc_pkg::fmt_e'(cfg_data_i[0]);
        hpc_pkg::CfgFadeLevel:   level_q <= cfg_data_i[hpc_pkg::LevelW-1:0];
        default: ;  // unknown index: write dropped
      endcase
    end
  end

  // Levels 65..127 saturate to full; bit 6 set means at least 64.
  logic [hpc_pkg::LevelW-1:0] lvl_new;
  logic [hpc_pkg::LevelW-1:0] lvl_old;

  assign lvl_new = level_q[hpc_pkg::LevelW-1] ? hpc_pkg::LevelFull : level_q;
  assign lvl_old = hpc_pkg::LevelFull - lvl_new;

  // ---------------------------------------------------------- handshakes
  logic s1_valid_q;
  logic out_valid_q;
  logic out_en;
  logic s1_en;
  logic in_acc;

  assign out_en     = !out_valid_q || !out_stall_i;
  assign s1_en      = !s1_valid_q || out_en;
  assign in_stall_o = !s1_en;
  assign in_acc     = in_valid_i && s1_en;

  // --------------------------------------------------------- input stage
  logic [hpc_pkg::PixW-1:0] new_q;
  logic [hpc_pkg::PixW-1:0] old_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_en) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      new_q <= new_pixel_i;
      old_q <= old_pixel_i;
    end
  end

  // ---------------------------------------------------------- blend math
  // Packed lanes: blue at bit 0, red at bit 10/11, green at bit 21.
  logic [hpc_pkg::SumW-1:0] sum;
  logic [hpc_pkg::SumW-1:0] masked;
  logic [hpc_pkg::SumW-1:0] folded;
  logic [hpc_pkg::SumW-1:0] shifted;
  logic [hpc_pkg::PixW-1:0] blended_d;

  always_comb begin
    sum = hpc_pkg::low_term(fmt_q, new_q[7:0], lvl_new)
        + hpc_pkg::high_term(fmt_q, new_q[15:8], lvl_new)
        + hpc_pkg::low_term(fmt_q, old_q[7:0], lvl_old)
        + hpc_pkg::high_term(fmt_q, old_q[15:8], lvl_old);
    masked  = sum & ((fmt_q == hpc_pkg::Rgb565) ? hpc_pkg::Mask565 : hpc_pkg::Mask555);
    folded  = masked | (masked >> 16);
    shifted = (fmt_q == hpc_pkg::Rgb565) ? (folded >> hpc_pkg::Shift565)
                                         : (folded >> hpc_pkg::Shift555);
    blended_d = shifted[hpc_pkg::PixW-1:0];
  end

  // -------------------------------------------------------- result stage
  logic [hpc_pkg::PixW-1:0] blended_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && s1_valid_q) begin
      blended_q <= blended_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign blended_pixel_o = blended_q;

  // ---------------------------------------------------------- assertions
  `HPC_ASSERT(a_no_overrun,
    !(in_acc && s1_valid_q && out_valid_q && out_stall_i),
    "item taken while both stages blocked")
  `HPC_ASSERT_IMPL(a_accept_fills, in_acc, ##1 s1_valid_q,
    "accepted item did not land in input stage")
  `HPC_ASSERT(a_weights_sum, (lvl_new + lvl_old) == hpc_pkg::LevelFull,
    "blend weights do not add to full level")
  `HPC_ASSERT_IMPL(a_555_top_bit, s1_valid_q && fmt_q == hpc_pkg::Rgb555,
    !blended_d[hpc_pkg::PixW-1], "RGB555 result has bit 15 set")

endmodule
